### hdl/otpt_pkg.sv
// shared constants, types and helpers of the one-shot timer pool
`timescale 1ns / 1ps
`default_nettype none
package otpt_pkg;

   localparam int LONG_SLOTS  = 2;
   localparam int SHORT_SLOTS = 3;
   localparam int SHORT_WIDTH = 16;
   localparam int LONG_WIDTH  = 32;

   localparam int TOTAL_SLOTS = LONG_SLOTS + SHORT_SLOTS;
   localparam int SLOT_IDX_W  = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;

   localparam int KIND_W = 3;
   localparam int ID_W   = 8;
   localparam int LEN_W  = 32;

   localparam logic [LEN_W-1:0] LONG_LIMIT  = LEN_W'((64'd1 << LONG_WIDTH) - 64'd1);
   localparam logic [LEN_W-1:0] SHORT_LIMIT = LEN_W'((64'd1 << SHORT_WIDTH) - 64'd1);

   // raw command codes on the request channel
   localparam logic [KIND_W-1:0] KIND_ACQUIRE = KIND_W'(0);
   localparam logic [KIND_W-1:0] KIND_RELEASE = KIND_W'(1);
   localparam logic [KIND_W-1:0] KIND_START   = KIND_W'(2);
   localparam logic [KIND_W-1:0] KIND_QUERY   = KIND_W'(3);
   localparam logic [KIND_W-1:0] KIND_TICK    = KIND_W'(4);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      OP_ACQUIRE,
      OP_RELEASE,
      OP_START,
      OP_QUERY,
      OP_TICK
   } otpt_op_type;

   typedef struct packed {
      otpt_op_type      op;
      logic [ID_W-1:0]  owner_id;
      logic             timer_class;
      logic [LEN_W-1:0] pulse_length;
   } otpt_cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXPIRE
   } otpt_state_type;

   // long slots come first, short slots follow
   function automatic logic [LEN_W-1:0] slot_limit(input logic [SLOT_IDX_W-1:0] idx);
      logic [LEN_W-1:0] lim;
      lim = (int'(idx) < LONG_SLOTS) ? LONG_LIMIT : SHORT_LIMIT;
      return lim;
   endfunction

endpackage
`default_nettype wire

### hdl/otpt_req_if.sv
// request channel of the timer pool
`timescale 1ns / 1ps
`default_nettype none
interface otpt_req_if;
   import otpt_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [ID_W-1:0]   owner_id;
   logic              timer_class;
   logic [LEN_W-1:0]  pulse_length;

   modport source (output valid, output kind, output owner_id, output timer_class,
                   output pulse_length, input ready);
   modport sink   (input valid, input kind, input owner_id, input timer_class,
                   input pulse_length, output ready);
endinterface
`default_nettype wire

### hdl/otpt_rsp_if.sv
// response channel of the timer pool
`timescale 1ns / 1ps
`default_nettype none
interface otpt_rsp_if;
   import otpt_pkg::*;

   logic             valid;
   logic             ready;
   logic             event_res;
   logic             accepted;
   logic [ID_W-1:0]  reply_id;
   logic [LEN_W-1:0] max_length;
   logic             last;

   modport source (output valid, output event_res, output accepted, output reply_id,
                   output max_length, output last, input ready);
   modport sink   (input valid, input event_res, input accepted, input reply_id,
                   input max_length, input last, output ready);
endinterface
`default_nettype wire

### hdl/otpt_front.sv
// front end: takes request words, decodes the command, drops unused codes
`timescale 1ns / 1ps
`default_nettype none
module otpt_front (
   otpt_req_if.sink              req,
   input  wire logic             queue_full,
   output logic                  push_valid,
   output otpt_pkg::otpt_cmd_type push_cmd
);
   import otpt_pkg::*;

   logic known;

   assign req.ready = !queue_full;

   always_comb begin
      known       = 1'b1;
      push_cmd.op = OP_TICK;
      unique case (req.kind)
         KIND_ACQUIRE: push_cmd.op = OP_ACQUIRE;
         KIND_RELEASE: push_cmd.op = OP_RELEASE;
         KIND_START:   push_cmd.op = OP_START;
         KIND_QUERY:   push_cmd.op = OP_QUERY;
         KIND_TICK:    push_cmd.op = OP_TICK;
         default:      known       = 1'b0;
      endcase
      push_cmd.owner_id     = req.owner_id;
      push_cmd.timer_class  = req.timer_class;
      push_cmd.pulse_length = req.pulse_length;
   end

   // unused codes are consumed with no effect
   assign push_valid = req.valid && req.ready && known;

endmodule
`default_nettype wire

### hdl/otpt_queue.sv
// short command queue between front end and engine
`timescale 1ns / 1ps
`default_nettype none
module otpt_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push_valid,
   input  wire otpt_pkg::otpt_cmd_type push_cmd,
   output logic                        full,
   input  wire logic                   pop,
   output logic                        empty,
   output otpt_pkg::otpt_cmd_type      head
);
   import otpt_pkg::*;

   otpt_cmd_type      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] n;
      n = (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + QPTR_W'(1);
      return n;
   endfunction

   assign full  = (int'(count_ff) == QUEUE_DEPTH);
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_valid ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

### hdl/otpt_engine.sv
// back end: slot table, command execution and expiry scan
`timescale 1ns / 1ps
`default_nettype none
module otpt_engine (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   empty,
   input  wire otpt_pkg::otpt_cmd_type head,
   output logic                        pop,
   otpt_rsp_if.source                  rsp
);
   import otpt_pkg::*;

   otpt_state_type         state_ff, state_in;
   logic [TOTAL_SLOTS-1:0] busy_ff, busy_in;
   logic [TOTAL_SLOTS-1:0] running_ff, running_in;
   logic [TOTAL_SLOTS-1:0] mask_ff, mask_in;
   logic [ID_W-1:0]        owner_ff [TOTAL_SLOTS];
   logic [ID_W-1:0]        owner_in [TOTAL_SLOTS];
   logic [LEN_W-1:0]       remain_ff [TOTAL_SLOTS];
   logic [LEN_W-1:0]       remain_in [TOTAL_SLOTS];

   logic             rsp_valid_ff, rsp_valid_in;
   logic             event_ff, event_in;
   logic             acc_ff, acc_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [LEN_W-1:0] maxlen_ff, maxlen_in;
   logic             last_ff, last_in;

   logic                  hit, free_hit, out_free;
   logic [SLOT_IDX_W-1:0] hit_idx, free_idx, exp_idx;
   logic [TOTAL_SLOTS-1:0] exp_onehot, rest;

   // lowest busy slot owned by the head id
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = TOTAL_SLOTS - 1; i >= 0; i--) begin
         if (busy_ff[i] && owner_ff[i] == head.owner_id) begin
            hit     = 1'b1;
            hit_idx = SLOT_IDX_W'(i);
         end
      end
   end

   // lowest free slot of the requested class
   always_comb begin
      free_hit = 1'b0;
      free_idx = '0;
      for (int i = TOTAL_SLOTS - 1; i >= 0; i--) begin
         if (!busy_ff[i] && ((i < LONG_SLOTS) == head.timer_class)) begin
            free_hit = 1'b1;
            free_idx = SLOT_IDX_W'(i);
         end
      end
   end

   // lowest pending expiry
   always_comb begin
      exp_idx    = '0;
      exp_onehot = '0;
      for (int i = TOTAL_SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            exp_idx    = SLOT_IDX_W'(i);
            exp_onehot = TOTAL_SLOTS'(1) << i;
         end
      end
      rest = mask_ff & ~exp_onehot;
   end

   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      running_in   = running_ff;
      mask_in      = mask_ff;
      owner_in     = owner_ff;
      remain_in    = remain_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      event_in     = event_ff;
      acc_in       = acc_ff;
      id_in        = id_ff;
      maxlen_in    = maxlen_ff;
      last_in      = last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!empty && out_free) begin
               pop       = 1'b1;
               event_in  = 1'b0;
               acc_in    = 1'b0;
               id_in     = head.owner_id;
               maxlen_in = '0;
               last_in   = 1'b1;
               unique case (head.op)
                  OP_ACQUIRE: begin
                     rsp_valid_in = 1'b1;
                     if (free_hit) begin
                        busy_in[free_idx]    = 1'b1;
                        owner_in[free_idx]   = head.owner_id;
                        running_in[free_idx] = 1'b0;
                        remain_in[free_idx]  = '0;
                        acc_in               = 1'b1;
                     end
                  end
                  OP_RELEASE: begin
                     rsp_valid_in = 1'b1;
                     if (hit) begin
                        busy_in[hit_idx]    = 1'b0;
                        owner_in[hit_idx]   = '0;
                        running_in[hit_idx] = 1'b0;
                        remain_in[hit_idx]  = '0;
                        acc_in              = 1'b1;
                     end
                  end
                  OP_START: begin
                     rsp_valid_in = 1'b1;
                     if (hit && head.pulse_length != '0
                         && head.pulse_length <= slot_limit(hit_idx)) begin
                        remain_in[hit_idx]  = head.pulse_length;
                        running_in[hit_idx] = 1'b1;
                        acc_in              = 1'b1;
                     end
                  end
                  OP_QUERY: begin
                     rsp_valid_in = 1'b1;
                     if (hit) begin
                        maxlen_in = slot_limit(hit_idx);
                        acc_in    = 1'b1;
                     end
                  end
                  OP_TICK: begin
                     // all running slots count down together, expiries are queued in a mask
                     for (int i = 0; i < TOTAL_SLOTS; i++) begin
                        mask_in[i] = 1'b0;
                        if (running_ff[i]) begin
                           remain_in[i] = remain_ff[i] - LEN_W'(1);
                           if (remain_ff[i] == LEN_W'(1)) begin
                              running_in[i] = 1'b0;
                              mask_in[i]    = 1'b1;
                           end
                        end
                     end
                     if (mask_in != '0) begin
                        state_in = ST_EXPIRE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_EXPIRE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               event_in     = 1'b1;
               acc_in       = 1'b1;
               id_in        = owner_ff[exp_idx];
               maxlen_in    = '0;
               last_in      = (rest == '0);
               mask_in      = rest;
               if (rest == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= '0;
         running_ff   <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         running_ff   <= running_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      owner_ff  <= owner_in;
      remain_ff <= remain_in;
      event_ff  <= event_in;
      acc_ff    <= acc_in;
      id_ff     <= id_in;
      maxlen_ff <= maxlen_in;
      last_ff   <= last_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.event_res  = event_ff;
   assign rsp.accepted   = acc_ff;
   assign rsp.reply_id   = id_ff;
   assign rsp.max_length = maxlen_ff;
   assign rsp.last       = last_ff;

endmodule
`default_nettype wire

### hdl/one_shot_pulse_timer_pool.sv
// top level of the one-shot pulse timer pool
//
//   channel | direction | payload                                         | handshake
//   --------+-----------+-------------------------------------------------+------------
//   req     | in        | kind, owner_id, timer_class, pulse_length       | valid/ready
//   rsp     | out       | event_res, accepted, reply_id, max_length, last | valid/ready
//
// each command word but a tick yields one reply word; a tick yields one event word per
// expiring slot through the one-word output register and takes no command until done
// an accepted command is written to the queue, then read into the output register
// reset is synchronous and clears the slot flags, the queue and the output valid flag
// a stalled response holds the engine; the two-word queue keeps req open until it fills
`timescale 1ns / 1ps
`default_nettype none
module one_shot_pulse_timer_pool (
   input  wire logic  clock,
   input  wire logic  reset,
   otpt_req_if.sink   req,
   otpt_rsp_if.source rsp
);
   import otpt_pkg::*;

   // front to queue
   logic         push_valid;
   otpt_cmd_type push_cmd;
   logic         queue_full;

   // queue to engine
   logic         queue_empty;
   logic         queue_pop;
   otpt_cmd_type queue_head;

   // decode: unused codes are taken and dropped here
   otpt_front u_front (
      .req        (req),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   // decouples request acceptance from a stalled or busy engine
   otpt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (queue_pop),
      .empty      (queue_empty),
      .head       (queue_head)
   );

   // slot table, lookups, countdown and the expiry scan in slot order
   otpt_engine u_engine (
      .clock (clock),
      .reset (reset),
      .empty (queue_empty),
      .head  (queue_head),
      .pop   (queue_pop),
      .rsp   (rsp)
   );

endmodule
`default_nettype wire
